/* src/pid_pkg.sv */
// Package for the fixed-point PID controller: payload and configuration types,
// the control word of the sequencer and its microprogram.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package pid_pkg;

    // Payload of the input channel.
    typedef struct packed {
        logic               req_type;
        logic signed [31:0] error_sample;
    } pid_in_t;

    // Payload of the output channel.
    typedef struct packed {
        logic signed [31:0] drive;
        logic               drive_clamped;
        logic               integ_clamped;
    } pid_out_t;

    // Configuration registers: gains and scales Q16.16, period and limits unsigned UQ15.16.
    typedef struct packed {
        logic signed [31:0] prop_gain;
        logic signed [31:0] integ_gain;
        logic signed [31:0] deriv_gain;
        logic signed [31:0] error_scale;
        logic signed [31:0] drive_scale;
        logic        [30:0] sample_period;
        logic        [30:0] drive_limit;
        logic        [30:0] integrator_limit;
    } pid_cfg_t;

    localparam pid_cfg_t CFG_RESET = '{
        prop_gain:        32'sd0,
        integ_gain:       32'sd0,
        deriv_gain:       32'sd0,
        error_scale:      32'sd65536,
        drive_scale:      32'sd65536,
        sample_period:    31'd655,
        drive_limit:      31'h7FFF_FFFF,
        integrator_limit: 31'h7FFF_FFFF
    };

    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_PROP_GAIN     = 3'd0;
    localparam cfg_idx_t REG_INTEG_GAIN    = 3'd1;
    localparam cfg_idx_t REG_DERIV_GAIN    = 3'd2;
    localparam cfg_idx_t REG_ERROR_SCALE   = 3'd3;
    localparam cfg_idx_t REG_DRIVE_SCALE   = 3'd4;
    localparam cfg_idx_t REG_SAMPLE_PERIOD = 3'd5;
    localparam cfg_idx_t REG_DRIVE_LIMIT   = 3'd6;
    localparam cfg_idx_t REG_INTEG_LIMIT   = 3'd7;

    // Quotient bits produced by the divider: |diff| << 16 plus half a period.
    localparam int DIV_BITS = 50;
    localparam int DIV_CNT_W = $clog2(DIV_BITS);

    // Multiplier operand sources.
    typedef enum logic [2:0] {
        MA_ERR_IN,
        MA_E,
        MA_ESUM,
        MA_T,
        MA_Q,
        MA_S
    } mul_a_t;

    typedef enum logic [2:0] {
        MB_ESCALE,
        MB_PER,
        MB_IGAIN,
        MB_DGAIN,
        MB_PGAIN,
        MB_DSCALE
    } mul_b_t;

    // Destination of the rounded product.
    typedef enum logic [2:0] {
        DST_NONE,
        DST_E,
        DST_P,
        DST_T,
        DST_D
    } dst_t;

    typedef enum logic [2:0] {
        ALU_NOP,
        ALU_PREP,
        ALU_ACC,
        ALU_SUM,
        ALU_COMMIT,
        ALU_CLEAR
    } alu_t;

    typedef enum logic [1:0] {
        COND_NEVER,
        COND_CLEAR,
        COND_DIV_BUSY,
        COND_OUT_BUSY
    } cond_t;

    typedef logic [3:0] pc_t;

    // Microprogram addresses.
    localparam pc_t S_MUL_ERR  = 4'd0;
    localparam pc_t S_RND_E    = 4'd1;
    localparam pc_t S_PREP     = 4'd2;
    localparam pc_t S_DIV_GO   = 4'd3;
    localparam pc_t S_RND_T    = 4'd4;
    localparam pc_t S_MUL_INC  = 4'd5;
    localparam pc_t S_RND_INC  = 4'd6;
    localparam pc_t S_ACC      = 4'd7;
    localparam pc_t S_DIV_WAIT = 4'd8;
    localparam pc_t S_MUL_D    = 4'd9;
    localparam pc_t S_RND_D    = 4'd10;
    localparam pc_t S_SUM      = 4'd11;
    localparam pc_t S_MUL_DRV  = 4'd12;
    localparam pc_t S_OUT_WAIT = 4'd13;
    localparam pc_t S_EMIT     = 4'd14;
    localparam pc_t S_CLEAR    = 4'd15;

    typedef struct packed {
        mul_a_t mul_a;
        mul_b_t mul_b;
        logic   mul_en;
        logic   rnd_sh17;
        dst_t   dst;
        logic   div_start;
        alu_t   alu;
        logic   emit;
        cond_t  cond;
        pc_t    target;
        logic   last;
    } pid_ctrl_t;

    // Status that the sequencer branches on.
    typedef struct packed {
        logic clear_req;
        logic div_busy;
        logic out_busy;
    } pid_stat_t;

    localparam pid_ctrl_t CTRL_NOP = '{
        mul_a:     MA_E,
        mul_b:     MB_ESCALE,
        mul_en:    1'b0,
        rnd_sh17:  1'b0,
        dst:       DST_NONE,
        div_start: 1'b0,
        alu:       ALU_NOP,
        emit:      1'b0,
        cond:      COND_NEVER,
        target:    S_MUL_ERR,
        last:      1'b0
    };

    // The microprogram. A product taken in one step is rounded in a later one.
    function automatic pid_ctrl_t ucode(input pc_t pc);
        pid_ctrl_t cw;
        cw = CTRL_NOP;
        unique case (pc)
            S_MUL_ERR:
            begin
                cw.mul_a  = MA_ERR_IN;
                cw.mul_b  = MB_ESCALE;
                cw.mul_en = 1'b1;
                cw.cond   = COND_CLEAR;
                cw.target = S_CLEAR;
            end
            S_RND_E:
            begin
                cw.dst = DST_E;
            end
            S_PREP:
            begin
                cw.alu    = ALU_PREP;
                cw.mul_a  = MA_E;
                cw.mul_b  = MB_PGAIN;
                cw.mul_en = 1'b1;
            end
            S_DIV_GO:
            begin
                cw.div_start = 1'b1;
                cw.dst       = DST_P;
                cw.mul_a     = MA_ESUM;
                cw.mul_b     = MB_PER;
                cw.mul_en    = 1'b1;
            end
            S_RND_T:
            begin
                cw.rnd_sh17 = 1'b1;
                cw.dst      = DST_T;
            end
            S_MUL_INC:
            begin
                cw.mul_a  = MA_T;
                cw.mul_b  = MB_IGAIN;
                cw.mul_en = 1'b1;
            end
            S_RND_INC:
            begin
                cw.dst = DST_T;
            end
            S_ACC:
            begin
                cw.alu = ALU_ACC;
            end
            S_DIV_WAIT:
            begin
                cw.cond   = COND_DIV_BUSY;
                cw.target = S_DIV_WAIT;
            end
            S_MUL_D:
            begin
                cw.mul_a  = MA_Q;
                cw.mul_b  = MB_DGAIN;
                cw.mul_en = 1'b1;
            end
            S_RND_D:
            begin
                cw.dst = DST_D;
            end
            S_SUM:
            begin
                cw.alu = ALU_SUM;
            end
            S_MUL_DRV:
            begin
                cw.mul_a  = MA_S;
                cw.mul_b  = MB_DSCALE;
                cw.mul_en = 1'b1;
            end
            S_OUT_WAIT:
            begin
                cw.cond   = COND_OUT_BUSY;
                cw.target = S_OUT_WAIT;
            end
            S_EMIT:
            begin
                cw.emit = 1'b1;
                cw.alu  = ALU_COMMIT;
                cw.last = 1'b1;
            end
            S_CLEAR:
            begin
                cw.alu  = ALU_CLEAR;
                cw.last = 1'b1;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

/* src/pid_div.sv */
// Radix-2 restoring divider for the derivative term: rounds |diff| << 16 by the
// sample period to nearest and saturates the signed quotient to 32 bits.
// Depends on pid_pkg.
`default_nettype none

module pid_div
    import pid_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [32:0] diff,
    input  wire logic        [30:0] per,
    output logic                    busy,
    output logic signed [31:0]      q
);

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_FIX
    } div_state_t;

    div_state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic signed [31:0]       q_reg, q_next;
    logic [DIV_BITS-1:0]      dq_reg, dq_next;
    logic [30:0]              rem_reg, rem_next;
    logic                     neg_reg, neg_next;

    logic [32:0]              mag;
    logic [31:0]              trial;
    logic                     fits;
    logic                     over;

    always_comb
    begin
        mag   = diff[32] ? 33'(-diff) : 33'(diff);
        trial = {rem_reg, dq_reg[DIV_BITS-1]};
        fits  = (trial >= {1'b0, per});
        over  = |dq_reg[DIV_BITS-1:31];

        state_next = state_reg;
        cnt_next   = cnt_reg;
        q_next     = q_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;

        unique case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    // Half a period is added up front so that truncation rounds.
                    dq_next    = {1'b0, mag, 16'd0} + DIV_BITS'(per[30:1]);
                    rem_next   = '0;
                    neg_next   = diff[32];
                    cnt_next   = '0;
                    state_next = DV_RUN;
                end
            end
            DV_RUN:
            begin
                rem_next = fits ? 31'(trial - {1'b0, per}) : trial[30:0];
                dq_next  = {dq_reg[DIV_BITS-2:0], fits};
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_BITS - 1))
                begin
                    state_next = DV_FIX;
                end
            end
            DV_FIX:
            begin
                priority if (over)
                begin
                    q_next = neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end
                else
                begin
                    q_next = neg_reg ? -$signed(dq_reg[31:0]) : $signed(dq_reg[31:0]);
                end
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            q_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            q_reg     <= q_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign busy = (state_reg != DV_IDLE);
    assign q    = q_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == DV_IDLE)
        else $error("divider started while a division was in progress");

    a_rem_below_per: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == DV_RUN |-> {1'b0, rem_reg} < {1'b0, per})
        else $error("partial remainder reached the divisor");

    a_fix_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == DV_FIX |=> state_reg == DV_IDLE && !busy)
        else $error("divider did not finish after the correction cycle");
`endif

endmodule

`default_nettype wire

/* src/pid_dpath.sv */
// Datapath of the PID controller: shared multiplier with rounding and
// saturation, integrator and sum clamps, state registers and the divider.
// Depends on pid_pkg and pid_div.
`default_nettype none

module pid_dpath
    import pid_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      load,
    input  wire pid_in_t   in_item,
    input  wire pid_cfg_t  cfg,
    input  wire pid_ctrl_t ctrl,
    output logic           clear_req,
    output logic           div_busy,
    output pid_out_t       result
);

    typedef struct packed {
        logic signed [31:0] val;
        logic               hit;
    } clamp_t;

    localparam logic [64:0] RND_HALF16 = 65'h0_0000_0000_0000_8000;
    localparam logic [64:0] RND_HALF17 = 65'h0_0000_0000_0001_0000;

    function automatic clamp_t clamp_sym(input logic signed [33:0] v,
                                         input logic [30:0] lim);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        clamp_t r;
        hi = {3'b000, lim};
        lo = -hi;
        r.hit = 1'b1;
        priority if (v > hi)
        begin
            r.val = hi[31:0];
        end
        else if (v < lo)
        begin
            r.val = lo[31:0];
        end
        else
        begin
            r.val = v[31:0];
            r.hit = 1'b0;
        end
        return r;
    endfunction

    logic signed [31:0] err_in_reg;
    logic               clear_reg;
    logic signed [31:0] e_reg;
    logic signed [31:0] last_reg;
    logic signed [31:0] integ_reg;
    logic signed [32:0] esum_reg;
    logic signed [32:0] diff_reg;
    logic signed [31:0] p_reg;
    logic signed [31:0] t_reg;
    logic signed [31:0] d_reg;
    logic signed [31:0] an_reg;
    logic               ihit_reg;
    logic signed [31:0] s_reg;
    logic               dhit_reg;
    logic signed [64:0] prod_reg;

    logic [30:0]        per_eff;
    logic signed [32:0] a_op;
    logic signed [31:0] b_op;
    logic signed [64:0] prod_full;
    logic [64:0]        rnd_sum;
    logic [48:0]        rnd_hi;
    logic signed [31:0] rnd_val;
    logic signed [32:0] acc_sum;
    logic signed [31:0] acc_sat;
    logic signed [33:0] pid_sum;
    clamp_t             acc_clamp;
    clamp_t             sum_clamp;
    logic signed [31:0] div_q;

    // A zero period is used as the smallest positive step.
    assign per_eff = (cfg.sample_period == 31'd0) ? 31'd1 : cfg.sample_period;

    always_comb
    begin
        unique case (ctrl.mul_a)
            MA_ERR_IN: a_op = {err_in_reg[31], err_in_reg};
            MA_E:      a_op = {e_reg[31], e_reg};
            MA_ESUM:   a_op = esum_reg;
            MA_T:      a_op = {t_reg[31], t_reg};
            MA_Q:      a_op = {div_q[31], div_q};
            MA_S:      a_op = {s_reg[31], s_reg};
            default:   a_op = '0;
        endcase

        unique case (ctrl.mul_b)
            MB_ESCALE: b_op = cfg.error_scale;
            MB_PER:    b_op = {1'b0, per_eff};
            MB_IGAIN:  b_op = cfg.integ_gain;
            MB_DGAIN:  b_op = cfg.deriv_gain;
            MB_PGAIN:  b_op = cfg.prop_gain;
            MB_DSCALE: b_op = cfg.drive_scale;
            default:   b_op = '0;
        endcase
    end

    assign prod_full = a_op * b_op;

    // Round to nearest, ties away from zero: a negative product takes one less
    // than half so that the arithmetic shift lands on the right side.
    always_comb
    begin
        rnd_sum = prod_reg + (ctrl.rnd_sh17 ? RND_HALF17 : RND_HALF16)
                  - {64'd0, prod_reg[64]};
        rnd_hi  = ctrl.rnd_sh17 ? {rnd_sum[64], rnd_sum[64:17]} : rnd_sum[64:16];
        priority if (&rnd_hi[48:31] || ~|rnd_hi[48:31])
        begin
            rnd_val = rnd_hi[31:0];
        end
        else
        begin
            rnd_val = rnd_hi[48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    always_comb
    begin
        acc_sum = {integ_reg[31], integ_reg} + {t_reg[31], t_reg};
        priority if (acc_sum[32] == acc_sum[31])
        begin
            acc_sat = acc_sum[31:0];
        end
        else
        begin
            acc_sat = acc_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        acc_clamp = clamp_sym({{2{acc_sat[31]}}, acc_sat}, cfg.integrator_limit);

        pid_sum   = {{2{p_reg[31]}}, p_reg} + {{2{an_reg[31]}}, an_reg}
                    + {{2{d_reg[31]}}, d_reg};
        sum_clamp = clamp_sym(pid_sum, cfg.drive_limit);
    end

    pid_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.div_start),
        .diff  (diff_reg),
        .per   (per_eff),
        .busy  (div_busy),
        .q     (div_q)
    );

    // Controller state: integrator and previous scaled error.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
            last_reg  <= '0;
        end
        else
        begin
            unique case (ctrl.alu)
                ALU_COMMIT:
                begin
                    integ_reg <= an_reg;
                    last_reg  <= e_reg;
                end
                ALU_CLEAR:
                begin
                    integ_reg <= '0;
                    last_reg  <= '0;
                end
                default:
                begin
                    integ_reg <= integ_reg;
                    last_reg  <= last_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            err_in_reg <= in_item.error_sample;
            clear_reg  <= in_item.req_type;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_full;
        end
        unique case (ctrl.dst)
            DST_E:   e_reg <= rnd_val;
            DST_P:   p_reg <= rnd_val;
            DST_T:   t_reg <= rnd_val;
            DST_D:   d_reg <= rnd_val;
            default: ;
        endcase
        if (ctrl.alu == ALU_PREP)
        begin
            esum_reg <= {e_reg[31], e_reg} + {last_reg[31], last_reg};
            diff_reg <= {e_reg[31], e_reg} - {last_reg[31], last_reg};
        end
        if (ctrl.alu == ALU_ACC)
        begin
            an_reg   <= acc_clamp.val;
            ihit_reg <= acc_clamp.hit;
        end
        if (ctrl.alu == ALU_SUM)
        begin
            s_reg    <= sum_clamp.val;
            dhit_reg <= sum_clamp.hit;
        end
    end

    assign clear_req = clear_reg;

    assign result = '{drive: rnd_val, drive_clamped: dhit_reg, integ_clamped: ihit_reg};

endmodule

`default_nettype wire

/* src/pid_seq.sv */
// Microcode sequencer of the PID controller: step counter, control word read
// from the program table and conditional jumps on datapath and output status.
// Depends on pid_pkg.
`default_nettype none

module pid_seq
    import pid_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire pid_stat_t stat,
    output logic           busy,
    output pid_ctrl_t      ctrl
);

    logic busy_reg, busy_next;
    pc_t  pc_reg, pc_next;
    logic cond_hit;

    always_comb
    begin
        ctrl = busy_reg ? ucode(pc_reg) : CTRL_NOP;

        unique case (ctrl.cond)
            COND_NEVER:    cond_hit = 1'b0;
            COND_CLEAR:    cond_hit = stat.clear_req;
            COND_DIV_BUSY: cond_hit = stat.div_busy;
            COND_OUT_BUSY: cond_hit = stat.out_busy;
            default:       cond_hit = 1'b0;
        endcase

        busy_next = busy_reg;
        pc_next   = pc_reg;
        priority if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                pc_next   = S_MUL_ERR;
            end
        end
        else if (cond_hit)
        begin
            pc_next = ctrl.target;
        end
        else if (ctrl.last)
        begin
            busy_next = 1'b0;
            pc_next   = S_MUL_ERR;
        end
        else
        begin
            pc_next = pc_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= S_MUL_ERR;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    assign busy = busy_reg;

`ifndef SYNTHESIS
    a_div_wait_holds: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && pc_reg == S_DIV_WAIT && stat.div_busy |=> pc_reg == S_DIV_WAIT)
        else $error("left the divider wait while the quotient was not ready");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> !stat.out_busy)
        else $error("result written while the output register was held");
`endif

endmodule

`default_nettype wire

/* src/pid_controller_step.sv */
// Top level of the fixed-point PID controller: handshakes, configuration
// registers and output register around the sequencer and datapath.
// Depends on pid_pkg, pid_seq and pid_dpath.
//
//  Channel | Role    | Signals                                  | Handshake
//  --------+---------+------------------------------------------+---------------------
//  in      | sink    | in_valid, in_stall, in_data (pid_in_t)    | valid and not stall
//  out     | source  | out_valid, out_stall, out_data (pid_out_t)| valid and not stall
//  cfg     | sink    | cfg_valid, cfg_ready, cfg_index, cfg_data | valid and ready
//
// A control step runs from acceptance until the next transaction can be
// accepted and includes a wait on the bit-serial divider for the derivative term.
// A clear transaction jumps straight to the clearing step and gives no result.
// The input stalls while the sequencer runs; the result waits in an output
// register, and a full, stalled output holds the program just before it writes.
// Reset clears the controller state, loads the register defaults and empties
// the output register.
`default_nettype none

module pid_controller_step
    import pid_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire pid_in_t     in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output pid_out_t         out_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire cfg_idx_t    cfg_index,
    input  wire logic [31:0] cfg_data
);

    pid_cfg_t  cfg_reg;
    logic      out_valid_reg, out_valid_next;
    pid_out_t  out_data_reg;

    logic      seq_busy;
    logic      in_take;
    pid_ctrl_t ctrl;
    pid_stat_t stat;
    logic      clear_req;
    logic      div_busy;
    pid_out_t  result;

    assign cfg_ready = 1'b1;
    assign in_stall  = seq_busy;
    assign in_take   = in_valid && !seq_busy;

    assign stat = '{clear_req: clear_req,
                    div_busy:  div_busy,
                    out_busy:  out_valid_reg && out_stall};

    pid_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_take),
        .stat  (stat),
        .busy  (seq_busy),
        .ctrl  (ctrl)
    );

    pid_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_take),
        .in_item   (in_data),
        .cfg       (cfg_reg),
        .ctrl      (ctrl),
        .clear_req (clear_req),
        .div_busy  (div_busy),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:     cfg_reg.prop_gain        <= cfg_data;
                REG_INTEG_GAIN:    cfg_reg.integ_gain       <= cfg_data;
                REG_DERIV_GAIN:    cfg_reg.deriv_gain       <= cfg_data;
                REG_ERROR_SCALE:   cfg_reg.error_scale      <= cfg_data;
                REG_DRIVE_SCALE:   cfg_reg.drive_scale      <= cfg_data;
                REG_SAMPLE_PERIOD: cfg_reg.sample_period    <= cfg_data[30:0];
                REG_DRIVE_LIMIT:   cfg_reg.drive_limit      <= cfg_data[30:0];
                REG_INTEG_LIMIT:   cfg_reg.integrator_limit <= cfg_data[30:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (ctrl.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
